// ===== rtl/bap_pkg.sv =====
`timescale 1ns / 1ps
// Package: field types, codes, controller/datapath interface structs for the allreduce engine
package bap_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int MAX_PEERS_DEF = 64;

	localparam int NODE_W     = 10;
	localparam int NT_W       = 11;
	localparam int RADIX_W    = 5;
	localparam int KIND_W     = 2;
	localparam int ACT_W      = 2;
	localparam int IDX_W      = 8;
	localparam int OFF_W      = RADIX_W;
	localparam int CMPW       = 12;
	localparam int DIVW       = NT_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [IDX_W-1:0]  IDX_MAX  = 8'd255;
	localparam logic [NODE_W-1:0] SONS_MAX = 10'd1023;

	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MARK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd2;

	localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WAIT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DONE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_TOTAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_RANK   = 2'd2;

	// peer list position select
	localparam logic [1:0] POS_PI     = 2'd0;
	localparam logic [1:0] POS_PI_CNT = 2'd1;
	localparam logic [1:0] POS_PI_OFF = 2'd2;

	// result peer select
	localparam logic [1:0] PEER_ZERO = 2'd0;
	localparam logic [1:0] PEER_TAB  = 2'd1;
	localparam logic [1:0] PEER_NODE = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] node;
	} item_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [NODE_W-1:0] peer;
	} result_t;

	typedef struct packed {
		logic             clr_step;
		logic             append;
		logic             mark;
		logic             pw_init;
		logic             pw_mul;
		logic             der_plain;
		logic             der_div;
		logic             div_start;
		logic             div_mod;
		logic             rd_tab;
		logic [1:0]       pos_sel;
		logic             rd_map;
		logic             pi_inc;
		logic             off_load;
		logic             off_dec;
		logic             ans;
		logic [ACT_W-1:0] ans_act;
		logic [1:0]       ans_sel;
	} cmd_t;

	typedef struct packed {
		logic dpend;
		logic clr_last;
		logic pw_grow;
		logic der_plain;
		logic div_done;
		logic rem_zero;
		logic idx_max;
		logic is_extra;
		logic pi_lt_cnt;
		logic pi_ge_2cnt;
		logic pi_ge_e;
		logic chk_ok;
		logic pi_ge_cnt_e;
		logic off_zero;
		logic arrived;
	} sts_t;

endpackage

// ===== rtl/bap_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by derive and level check
module bap_div import bap_pkg::*; #(
	parameter int W = DIVW
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int CNTW = $clog2(W + 1);

	logic [W-1:0]    quo_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [W:0]      shifted;
	logic [W:0]      diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/bap_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: config and derived registers, peer table, arrival map, progress index, result
module bap_datapath import bap_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_PEERS = MAX_PEERS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  item_t                 item,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  result_strobe,
	output result_t               result
);
	localparam int AW = $clog2(MAX_NODES);
	localparam int PW = $clog2(MAX_PEERS);
	localparam int CW = $clog2(MAX_PEERS + 1);

	logic [NT_W-1:0]    node_total_q;
	logic [RADIX_W-1:0] radix_q;
	logic [NODE_W-1:0]  own_rank_q;
	logic               dpend_q;

	logic [NT_W-1:0]    power_q;
	logic               is_extra_q;
	logic [NODE_W-1:0]  extra_sons_q;
	logic [CW-1:0]      peer_count_q;
	logic [IDX_W-1:0]   pi_q;
	logic [OFF_W-1:0]   off_q;
	logic [AW-1:0]      clr_addr_q;
	logic               strobe_q;
	result_t            res_q;

	logic [NODE_W-1:0]  tab_rd_q;
	logic               pos_ok_q;
	logic               arr_rd_q;
	logic               node_ok_q;
	logic [NODE_W-1:0]  node_q;

	logic [NODE_W-1:0]  peer_table [MAX_PEERS];
	logic               arrived_map [MAX_NODES];

	logic [NT_W-1:0]          n_eff;
	logic [RADIX_W-1:0]       k_eff;
	logic [OFF_W-1:0]         iv;
	logic [NT_W+RADIX_W-1:0]  prod;
	logic [CMPW-1:0]          pi_w;
	logic [CMPW-1:0]          cnt_w;
	logic [CMPW-1:0]          e_w;
	logic [CMPW-1:0]          pos_w;
	logic                     cnt_full;
	logic [NODE_W-1:0]        node_sel;
	logic [31:0]              nsel32;
	logic [31:0]              mark32;
	logic                     mark_ok;
	logic [DIVW-1:0]          div_a;
	logic [DIVW-1:0]          div_b;
	logic                     div_done;
	logic [DIVW-1:0]          div_quo;
	logic [DIVW-1:0]          div_rem;
	logic                     own_lt_rem;
	logic [CMPW-1:0]          sons_sum;

	assign n_eff = (node_total_q == '0) ? NT_W'(1) : node_total_q;
	assign k_eff = (radix_q < RADIX_W'(2)) ? RADIX_W'(2) : radix_q;
	assign iv    = k_eff - RADIX_W'(1);
	assign prod  = {{RADIX_W{1'b0}}, power_q} * {{NT_W{1'b0}}, k_eff};

	assign pi_w  = CMPW'(pi_q);
	assign cnt_w = CMPW'(peer_count_q);
	assign e_w   = CMPW'(extra_sons_q);

	always_comb begin
		case (cmd.pos_sel)
			POS_PI_CNT: pos_w = pi_w - cnt_w;
			POS_PI_OFF: pos_w = pi_w - CMPW'(off_q);
			default:    pos_w = pi_w;
		endcase
	end

	assign cnt_full = (peer_count_q == CW'(MAX_PEERS));
	assign node_sel = pos_ok_q ? tab_rd_q : '0;
	assign nsel32   = 32'(node_sel);
	assign mark32   = 32'(item.node);
	assign mark_ok  = (mark32 < 32'(MAX_NODES));

	// shared divider: extra-son split at derive, level boundary test at request
	assign div_a = cmd.div_mod ? DIVW'(pi_w - e_w) : (n_eff - power_q);
	assign div_b = cmd.div_mod ? DIVW'(iv) : power_q;

	bap_div #(.W(DIVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign own_lt_rem = ({1'b0, own_rank_q} < div_rem);
	assign sons_sum   = CMPW'(div_quo) + CMPW'(own_lt_rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_total_q <= NT_W'(1);
			radix_q      <= RADIX_W'(2);
			own_rank_q   <= '0;
			dpend_q      <= 1'b0;
		end else begin
			if (cmd.pw_init) dpend_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_NODE_TOTAL: begin
						node_total_q <= cfg_data[NT_W-1:0];
						dpend_q      <= 1'b1;
					end
					REG_RADIX: begin
						radix_q <= cfg_data[RADIX_W-1:0];
						dpend_q <= 1'b1;
					end
					REG_OWN_RANK: begin
						own_rank_q <= cfg_data[NODE_W-1:0];
						dpend_q    <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_extra_q   <= 1'b0;
			extra_sons_q <= '0;
			peer_count_q <= '0;
			pi_q         <= '0;
			off_q        <= '0;
			clr_addr_q   <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= cmd.ans;
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.append && !cnt_full) peer_count_q <= peer_count_q + CW'(1);
			if (cmd.pi_inc) pi_q <= pi_q + IDX_W'(1);
			if (cmd.off_load) off_q <= iv;
			else if (cmd.off_dec) off_q <= off_q - OFF_W'(1);
			if (cmd.der_plain) begin
				is_extra_q   <= (n_eff != power_q);
				extra_sons_q <= '0;
			end else if (cmd.der_div) begin
				is_extra_q   <= 1'b0;
				extra_sons_q <= (sons_sum > CMPW'(SONS_MAX)) ? SONS_MAX : sons_sum[NODE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pw_init) power_q <= NT_W'(1);
		else if (cmd.pw_mul) power_q <= prod[NT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.append && !cnt_full) peer_table[peer_count_q[PW-1:0]] <= item.node;
		if (cmd.rd_tab) begin
			tab_rd_q <= peer_table[pos_w[PW-1:0]];
			pos_ok_q <= (pos_w < cnt_w);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) arrived_map[clr_addr_q] <= 1'b0;
		else if (cmd.mark && mark_ok) arrived_map[mark32[AW-1:0]] <= 1'b1;
		if (cmd.rd_map) begin
			arr_rd_q  <= arrived_map[nsel32[AW-1:0]];
			node_ok_q <= (nsel32 < 32'(MAX_NODES));
			node_q    <= node_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ans) begin
			res_q.action <= cmd.ans_act;
			case (cmd.ans_sel)
				PEER_TAB:  res_q.peer <= node_sel;
				PEER_NODE: res_q.peer <= node_q;
				default:   res_q.peer <= '0;
			endcase
		end
	end

	assign sts.dpend       = dpend_q;
	assign sts.clr_last    = (clr_addr_q == AW'(MAX_NODES - 1));
	assign sts.pw_grow     = (prod <= {{RADIX_W{1'b0}}, n_eff});
	assign sts.der_plain   = (n_eff == power_q) || ({1'b0, own_rank_q} >= power_q);
	assign sts.div_done    = div_done;
	assign sts.rem_zero    = (div_rem == '0);
	assign sts.idx_max     = (pi_q == IDX_MAX);
	assign sts.is_extra    = is_extra_q;
	assign sts.pi_lt_cnt   = (pi_w < cnt_w);
	assign sts.pi_ge_2cnt  = (pi_w >= (cnt_w << 1));
	assign sts.pi_ge_e     = (pi_w >= e_w);
	assign sts.chk_ok      = (pi_w >= e_w + CMPW'(iv)) && (pi_w <= cnt_w);
	assign sts.pi_ge_cnt_e = (pi_w >= cnt_w + e_w);
	assign sts.off_zero    = (off_q == '0);
	assign sts.arrived     = node_ok_q & arr_rd_q;

	assign result_strobe = strobe_q;
	assign result        = res_q;

endmodule

// ===== rtl/bap_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: clear sweep, derive sequence and next-action scheduler state machine
module bap_ctrl import bap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KIND_W-1:0] kind,
	input  sts_t              sts,
	output logic              busy,
	output cmd_t              cmd
);
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_CLEAR   = 4'd1;
	localparam logic [3:0] ST_P_INIT  = 4'd2;
	localparam logic [3:0] ST_P_LOOP  = 4'd3;
	localparam logic [3:0] ST_P_WAIT  = 4'd4;
	localparam logic [3:0] ST_N_START = 4'd5;
	localparam logic [3:0] ST_X_LOOP  = 4'd6;
	localparam logic [3:0] ST_L1      = 4'd7;
	localparam logic [3:0] ST_CHK     = 4'd8;
	localparam logic [3:0] ST_CHK_W   = 4'd9;
	localparam logic [3:0] ST_B_LOOP  = 4'd10;
	localparam logic [3:0] ST_TAIL    = 4'd11;
	localparam logic [3:0] ST_RD2     = 4'd12;
	localparam logic [3:0] ST_RD3     = 4'd13;

	localparam logic [1:0] RET_SEND = 2'd0;
	localparam logic [1:0] RET_XL   = 2'd1;
	localparam logic [1:0] RET_L1   = 2'd2;
	localparam logic [1:0] RET_BL   = 2'd3;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] ret_q;
	logic [1:0] ret_d;

	assign busy = (state_q != ST_IDLE) || sts.dpend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q   <= RET_SEND;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (sts.dpend) begin
					state_d = ST_P_INIT;
				end else if (start) begin
					case (kind)
						KIND_APPEND: cmd.append = 1'b1;
						KIND_MARK:   cmd.mark = 1'b1;
						KIND_NEXT:   state_d = ST_N_START;
						default: ;
					endcase
				end
			end
			ST_P_INIT: begin
				cmd.pw_init = 1'b1;
				state_d     = ST_P_LOOP;
			end
			ST_P_LOOP: begin
				if (sts.pw_grow) begin
					cmd.pw_mul = 1'b1;
				end else if (sts.der_plain) begin
					cmd.der_plain = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_P_WAIT;
				end
			end
			ST_P_WAIT: begin
				if (sts.div_done) begin
					cmd.der_div = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_N_START: begin
				if (sts.idx_max) begin
					cmd.ans     = 1'b1;
					cmd.ans_act = ACT_DONE;
					state_d     = ST_IDLE;
				end else if (sts.is_extra) begin
					if (sts.pi_lt_cnt) begin
						cmd.rd_tab  = 1'b1;
						cmd.pos_sel = POS_PI;
						ret_d       = RET_SEND;
						state_d     = ST_RD2;
					end else begin
						state_d = ST_X_LOOP;
					end
				end else begin
					state_d = ST_L1;
				end
			end
			ST_X_LOOP: begin
				if (sts.pi_ge_2cnt || sts.idx_max) begin
					cmd.ans     = 1'b1;
					cmd.ans_act = ACT_DONE;
					state_d     = ST_IDLE;
				end else begin
					cmd.rd_tab  = 1'b1;
					cmd.pos_sel = POS_PI_CNT;
					ret_d       = RET_XL;
					state_d     = ST_RD2;
				end
			end
			ST_L1: begin
				if (sts.pi_ge_e) begin
					state_d = ST_CHK;
				end else if (sts.idx_max) begin
					cmd.ans     = 1'b1;
					cmd.ans_act = ACT_DONE;
					state_d     = ST_IDLE;
				end else begin
					cmd.rd_tab  = 1'b1;
					cmd.pos_sel = POS_PI;
					ret_d       = RET_L1;
					state_d     = ST_RD2;
				end
			end
			ST_CHK: begin
				if (sts.chk_ok) begin
					cmd.div_start = 1'b1;
					cmd.div_mod   = 1'b1;
					state_d       = ST_CHK_W;
				end else begin
					state_d = ST_TAIL;
				end
			end
			ST_CHK_W: begin
				cmd.div_mod = 1'b1;
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.off_load = 1'b1;
						state_d      = ST_B_LOOP;
					end else begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_B_LOOP: begin
				if (sts.off_zero) begin
					state_d = ST_TAIL;
				end else begin
					cmd.rd_tab  = 1'b1;
					cmd.pos_sel = POS_PI_OFF;
					ret_d       = RET_BL;
					state_d     = ST_RD2;
				end
			end
			ST_TAIL: begin
				if (sts.pi_ge_cnt_e || sts.idx_max) begin
					cmd.ans     = 1'b1;
					cmd.ans_act = ACT_DONE;
					state_d     = ST_IDLE;
				end else begin
					cmd.rd_tab  = 1'b1;
					cmd.pos_sel = sts.pi_lt_cnt ? POS_PI : POS_PI_CNT;
					ret_d       = RET_SEND;
					state_d     = ST_RD2;
				end
			end
			ST_RD2: begin
				if (ret_q == RET_SEND) begin
					cmd.ans     = 1'b1;
					cmd.ans_act = ACT_SEND;
					cmd.ans_sel = PEER_TAB;
					cmd.pi_inc  = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.rd_map = 1'b1;
					state_d    = ST_RD3;
				end
			end
			ST_RD3: begin
				if (!sts.arrived) begin
					cmd.ans     = 1'b1;
					cmd.ans_act = ACT_WAIT;
					cmd.ans_sel = PEER_NODE;
					state_d     = ST_IDLE;
				end else begin
					case (ret_q)
						RET_XL: begin
							cmd.pi_inc = 1'b1;
							state_d    = ST_X_LOOP;
						end
						RET_L1: begin
							cmd.pi_inc = 1'b1;
							state_d    = ST_L1;
						end
						default: begin
							cmd.off_dec = 1'b1;
							state_d     = ST_B_LOOP;
						end
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/butterfly_allreduce_progress_top.sv =====
`timescale 1ns / 1ps
// Top level of the butterfly allreduce progress engine
//
// Items enter on start/item and are taken at a clock edge with start high and
// busy low. Kind append and kind mark are taken while busy stays low,
// so such items can follow every cycle. A next request raises busy and yields
// one result: result_strobe is high for one cycle with result.action/peer.
// A request keeps busy high while it works: for every arrival bit it checks
// there is one peer table read, then one arrival map read, in turn, and where a
// level boundary is due it is tested on the shared one-bit-a-cycle divider. The
// result comes in the first cycle with busy low, so the next item can be taken
// at the end of that cycle.
// A register write on cfg_we/cfg_index/cfg_data raises busy while the radix
// power and the extra-son share are derived.
// After reset busy stays high while the arrival map is cleared one entry a
// cycle; register writes are taken during that time.
// Results cannot be held off: the receiver takes each one in its strobe cycle.
module butterfly_allreduce_progress_top import bap_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_PEERS = MAX_PEERS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  result_strobe,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	bap_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	bap_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_PEERS (MAX_PEERS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item          (item),
		.cmd           (cmd),
		.sts           (sts),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

// ===== rtl/bap_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the allreduce engine, bound to the top level
module bap_checker import bap_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input item_t                item,
	input logic                 result_strobe,
	input result_t              result,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index
);
	// a result only follows a cycle of request work
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without preceding request work");

	// table loads and marks give no result
	a_no_res_for_load: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind != KIND_NEXT) |=> !result_strobe)
		else $error("result after a non-request item");

	a_next_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind == KIND_NEXT) |=> busy)
		else $error("next request did not raise busy");

	a_done_peer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.action == ACT_DONE) |-> (result.peer == '0))
		else $error("done result with nonzero peer");

	a_cfg_derive: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == REG_NODE_TOTAL || cfg_index == REG_RADIX ||
			cfg_index == REG_OWN_RANK)) |=> busy)
		else $error("register write did not hold off items");

endmodule

bind butterfly_allreduce_progress_top bap_checker u_bap_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.item          (item),
	.result_strobe (result_strobe),
	.result        (result),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench: butterfly allreduce progress engine, self-checking against a local schedule predictor
module tb;
	import bap_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int ITEM_GOAL = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 40;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_t;

	typedef struct {
		op_t                   op;
		item_t                 it;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} step_t;

	typedef struct {
		bit extra;
		int sons;
		int k;
	} role_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	item_t                 item = '0;
	logic                  result_strobe;
	result_t               result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	step_t   pending_ops[$];
	result_t due_results[$];
	int      counted = 0;
	int      taken = 0;
	int      settle = 0;
	int      mismatches = 0;
	bit      we_next;

	// predicted engine state
	logic [NT_W-1:0]    cur_nodes;
	logic [RADIX_W-1:0] cur_radix;
	logic [NODE_W-1:0]  cur_rank;
	role_t              role;
	logic [NODE_W-1:0]  pl_table [MAX_PEERS_DEF];
	int                 pl_count;
	bit                 arrived_map [MAX_NODES_DEF];
	int                 pl_index;

	butterfly_allreduce_progress_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_strobe(result_strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic role_t derive_role(int nodes, int rdx, int rank);
		role_t d;
		int n, power, total;
		n = (nodes == 0) ? 1 : nodes;
		d.k = (rdx < 2) ? 2 : rdx;
		power = 1;
		while (power * d.k <= n)
			power *= d.k;
		d.extra = 1'b0;
		d.sons = 0;
		if (n != power) begin
			if (rank < power) begin
				total = n - power;
				d.sons = total / power + ((rank < total % power) ? 1 : 0);
				if (d.sons > 1023)
					d.sons = 1023;
			end else begin
				d.extra = 1'b1;
			end
		end
		return d;
	endfunction

	function automatic int peer_at(int pos);
		if (pos >= 0 && pos < pl_count && pos < MAX_PEERS_DEF)
			return pl_table[pos];
		return 0;
	endfunction

	function automatic result_t plan_next();
		result_t r;
		int cnt, e, iv, n, off;
		cnt = pl_count;
		r.action = ACT_DONE;
		r.peer = '0;
		if (pl_index >= IDX_MAX)
			return r;
		if (role.extra) begin
			if (pl_index < cnt) begin
				r.action = ACT_SEND;
				r.peer = NODE_W'(peer_at(pl_index));
				pl_index++;
				return r;
			end
			while (pl_index < 2 * cnt) begin
				if (pl_index >= IDX_MAX)
					return r;
				n = peer_at(pl_index - cnt);
				if (!arrived_map[n]) begin
					r.action = ACT_WAIT;
					r.peer = NODE_W'(n);
					return r;
				end
				pl_index++;
			end
			return r;
		end
		e = role.sons;
		iv = role.k - 1;
		while (pl_index < e) begin
			if (pl_index >= IDX_MAX)
				return r;
			n = peer_at(pl_index);
			if (!arrived_map[n]) begin
				r.action = ACT_WAIT;
				r.peer = NODE_W'(n);
				return r;
			end
			pl_index++;
		end
		// level boundary: previous radix-1 peers must all have arrived
		if (pl_index >= e + iv && pl_index <= cnt && (pl_index - e) % iv == 0) begin
			for (off = iv; off > 0; off--) begin
				n = peer_at(pl_index - off);
				if (!arrived_map[n]) begin
					r.action = ACT_WAIT;
					r.peer = NODE_W'(n);
					return r;
				end
			end
		end
		if (pl_index >= cnt + e || pl_index >= IDX_MAX)
			return r;
		if (pl_index < cnt) begin
			r.action = ACT_SEND;
			r.peer = NODE_W'(peer_at(pl_index));
			pl_index++;
		end else if (pl_index < e + cnt) begin
			r.action = ACT_SEND;
			r.peer = NODE_W'(peer_at(pl_index - cnt));
			pl_index++;
		end
		return r;
	endfunction

	// driver: presents queued items and register writes, updates the prediction on each accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			cfg_we <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			cur_nodes = NT_W'(1);
			cur_radix = RADIX_W'(2);
			cur_rank = '0;
			role = derive_role(1, 2, 0);
			pl_count = 0;
			pl_index = 0;
			foreach (pl_table[i])
				pl_table[i] = '0;
			foreach (arrived_map[i])
				arrived_map[i] = 1'b0;
			settle = 0;
		end else begin
			if (start && !busy) begin
				taken++;
				case (item.kind)
					KIND_APPEND: begin
						if (pl_count < MAX_PEERS_DEF) begin
							pl_table[pl_count] = item.node;
							pl_count++;
						end
					end
					KIND_MARK: arrived_map[item.node] = 1'b1;
					KIND_NEXT: due_results.push_back(plan_next());
					default: ;
				endcase
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_NODE_TOTAL: cur_nodes = cfg_data[NT_W-1:0];
					REG_RADIX:      cur_radix = cfg_data[RADIX_W-1:0];
					REG_OWN_RANK:   cur_rank = cfg_data[NODE_W-1:0];
					default: ;
				endcase
				role = derive_role(cur_nodes, cur_radix, cur_rank);
			end
			if (due_results.size() == 0 && !busy && !start && !cfg_we)
				settle++;
			else
				settle = 0;

			we_next = 1'b0;
			if (start && busy) begin
				// hold the item until taken
			end else if (pending_ops.size() == 0) begin
				start <= 1'b0;
			end else begin
				case (pending_ops[0].op)
					OP_ITEM: begin
						if (!(taken >= 400 && taken < 600) && $urandom_range(99) < 20) begin
							start <= 1'b0;
						end else begin
							start <= 1'b1;
							item <= pending_ops[0].it;
							pending_ops.pop_front();
						end
					end
					OP_CFG: begin
						start <= 1'b0;
						if (settle >= SETTLE_CYCLES) begin
							we_next = 1'b1;
							cfg_index <= pending_ops[0].idx;
							cfg_data <= pending_ops[0].data;
							pending_ops.pop_front();
							settle = 0;
						end
					end
					default: begin
						start <= 1'b0;
						if (settle >= SETTLE_CYCLES)
							pending_ops.pop_front();
					end
				endcase
			end
			cfg_we <= we_next;
		end
	end

	// monitor: every strobed result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (due_results.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("unexpected result: action %0d peer %0d",
						result.action, result.peer);
				mismatches++;
			end else begin
				if (result.action !== due_results[0].action ||
					result.peer !== due_results[0].peer) begin
					if (mismatches < REPORT_MAX)
						$display("mismatch: expected action %0d peer %0d, got action %0d peer %0d",
							due_results[0].action, due_results[0].peer,
							result.action, result.peer);
					mismatches++;
				end
				void'(due_results.pop_front());
			end
		end
	end

	task automatic add_item(logic [KIND_W-1:0] kind, int node);
		step_t s;
		s.op = OP_ITEM;
		s.it.kind = kind;
		s.it.node = NODE_W'(node);
		s.idx = '0;
		s.data = '0;
		pending_ops.push_back(s);
		counted++;
	endtask

	task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
		step_t s;
		s.op = OP_CFG;
		s.it = '0;
		s.idx = idx;
		s.data = CFG_DATA_W'(data);
		pending_ops.push_back(s);
	endtask

	task automatic add_noise();
		add_item(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 1023));
	endtask

	// one schedule: fresh registers, a peer list shaped for them, then arrivals and requests
	task automatic plan_round();
		role_t d;
		int nodes, rdx, rank, lvls, len, p, t;
		int ids[$];
		case ($urandom_range(0, 9))
			0:       rdx = $urandom_range(0, 31);
			1:       rdx = $urandom_range(5, 16);
			default: rdx = $urandom_range(2, 4);
		endcase
		case ($urandom_range(0, 19))
			0:       nodes = 0;
			1:       nodes = 1024;
			2:       nodes = $urandom_range(1025, 2047);
			3, 4:    nodes = $urandom_range(41, 1024);
			default: nodes = $urandom_range(1, 40);
		endcase
		case ($urandom_range(0, 9))
			0:       rank = 1023;
			1:       rank = 0;
			2, 3:    rank = $urandom_range(0, 1023);
			default: rank = $urandom_range(0, (nodes > 1024) ? 1023 : ((nodes > 0) ? nodes - 1 : 0));
		endcase
		add_cfg(REG_NODE_TOTAL, nodes);
		add_cfg(REG_RADIX, ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 63) << 5) | rdx) : rdx);
		add_cfg(REG_OWN_RANK, ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) << 10) | rank) : rank);
		if ($urandom_range(0, 9) == 0)
			add_cfg(REG_UNUSED, $urandom_range(0, 2047));
		d = derive_role(nodes, rdx, rank);
		lvls = $urandom_range(1, 3);
		len = d.extra ? $urandom_range(1, 3) : d.sons + lvls * (d.k - 1);
		if (len > 24)
			len = 24;
		for (p = 0; p < len; p++) begin
			ids.push_back($urandom_range(0, 1023));
			add_item(KIND_APPEND, ids[p]);
			if ($urandom_range(0, 9) < 3)
				add_item(KIND_NEXT, $urandom_range(0, 1023));
		end
		while (ids.size() != 0) begin
			repeat ($urandom_range(1, 2))
				add_item(KIND_NEXT, $urandom_range(0, 1023));
			t = $urandom_range(0, ids.size() - 1);
			add_item(KIND_MARK, ids[t]);
			ids.delete(t);
			if ($urandom_range(0, 9) == 0)
				add_noise();
		end
		repeat ($urandom_range(1, 3))
			add_item(KIND_NEXT, $urandom_range(0, 1023));
		if ($urandom_range(0, 3) == 0)
			pending_ops.push_back('{OP_DRAIN, '0, '0, '0});
	endtask

	initial begin
		// defaults, unknown kind, degenerate register values
		add_item(KIND_NEXT, 1023);
		add_item(KIND_UNUSED, 1023);
		add_item(KIND_UNUSED, 0);
		add_cfg(REG_RADIX, 0);
		add_cfg(REG_NODE_TOTAL, 0);
		add_cfg(REG_UNUSED, 2047);
		add_item(KIND_NEXT, 0);
		add_cfg(REG_NODE_TOTAL, 2047);
		add_cfg(REG_RADIX, 31);
		add_cfg(REG_OWN_RANK, 1023);
		add_item(KIND_NEXT, 0);
		// six ranks, radix two: one extra son, then single-peer levels
		add_cfg(REG_NODE_TOTAL, 6);
		add_cfg(REG_RADIX, 2);
		add_cfg(REG_OWN_RANK, 0);
		add_item(KIND_APPEND, 1023);
		add_item(KIND_APPEND, 0);
		add_item(KIND_APPEND, 5);
		add_item(KIND_APPEND, 1);
		add_item(KIND_NEXT, 0);
		add_item(KIND_MARK, 1023);
		add_item(KIND_NEXT, 0);
		add_item(KIND_NEXT, 0);
		add_item(KIND_MARK, 0);
		add_item(KIND_NEXT, 0);
		add_item(KIND_NEXT, 0);
		add_item(KIND_MARK, 5);
		add_item(KIND_NEXT, 0);
		add_item(KIND_NEXT, 0);
		add_item(KIND_MARK, 1);
		add_item(KIND_NEXT, 0);
		add_item(KIND_NEXT, 0);
		// same list seen as an extra node, then as a plain rank
		add_cfg(REG_OWN_RANK, 1023);
		add_item(KIND_NEXT, 0);
		add_cfg(REG_NODE_TOTAL, 1024);
		add_item(KIND_NEXT, 0);
		pending_ops.push_back('{OP_DRAIN, '0, '0, '0});

		while (counted < ITEM_GOAL)
			plan_round();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0)
			@(posedge clk);
		@(posedge clk);
		while (start || busy || due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#100000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
